@@ src/sti_pkg.sv @@
// Shared constants for the segment/triangle intersection unit.
// Holds the determinant point table and cross-product axis tables; no dependencies.
package sti_pkg;

   localparam int unsigned FIELD_BITS  = 48;
   localparam int unsigned EXT_BITS    = 64;
   localparam int unsigned POINT_COUNT = 5;
   localparam int unsigned DET_COUNT   = 8;
   localparam int unsigned PAIR_COUNT  = 4;

   typedef logic [2:0] point_sel_type;
   typedef logic [1:0] axis_sel_type;

   // point codes
   localparam point_sel_type PT_ORIGIN = 3'd0;
   localparam point_sel_type PT_DEST   = 3'd1;
   localparam point_sel_type PT_VA     = 3'd2;
   localparam point_sel_type PT_VB     = 3'd3;
   localparam point_sel_type PT_VC     = 3'd4;

   // each volume is (a-d).((b-d)x(c-d)), listed as a, b, c, d
   localparam point_sel_type DET_PTS [DET_COUNT][4] = '{
      '{PT_VA,     PT_VB,   PT_VC, PT_ORIGIN},
      '{PT_VA,     PT_VB,   PT_VC, PT_DEST},
      '{PT_ORIGIN, PT_DEST, PT_VA, PT_VB},
      '{PT_ORIGIN, PT_DEST, PT_VA, PT_VC},
      '{PT_ORIGIN, PT_DEST, PT_VB, PT_VA},
      '{PT_ORIGIN, PT_DEST, PT_VB, PT_VC},
      '{PT_ORIGIN, PT_DEST, PT_VC, PT_VA},
      '{PT_ORIGIN, PT_DEST, PT_VC, PT_VB}
   };

   localparam axis_sel_type AXIS_NEXT [3] = '{2'd1, 2'd2, 2'd0};
   localparam axis_sel_type AXIS_PREV [3] = '{2'd2, 2'd0, 2'd1};

endpackage

@@ src/sti_req_if.sv @@
// Request channel: one segment and one triangle per word.
// Depends on sti_pkg for the field width.
interface sti_req_if;
   import sti_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] seg_origin;
   logic [FIELD_BITS-1:0] seg_dest;
   logic [FIELD_BITS-1:0] tri_vertex_a;
   logic [FIELD_BITS-1:0] tri_vertex_b;
   logic [FIELD_BITS-1:0] tri_vertex_c;

   modport source (output valid, seg_origin, seg_dest, tri_vertex_a, tri_vertex_b,
                   tri_vertex_c, input ready);
   modport sink   (input valid, seg_origin, seg_dest, tri_vertex_a, tri_vertex_b,
                   tri_vertex_c, output ready);
endinterface

@@ src/sti_rsp_if.sv @@
// Response channel: one hit flag per word.
// No dependencies.
interface sti_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

@@ src/segment_triangle_intersect_unit.sv @@
// Segment/triangle intersection by signed volumes, seven register stages.
// An accepted request passes through the stage 1 to stage 7 registers; the stage 7 register drives the response.
// Throughput: one word per cycle; the whole pipe holds while the response register stalls.
// Reset (synchronous, active high) clears all stage valid bits; no other state.
// Depends on sti_pkg, sti_req_if and sti_rsp_if.
module segment_triangle_intersect_unit #(
   parameter int unsigned COORD_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   sti_req_if.sink   req_chan,
   sti_rsp_if.source rsp_chan
);
   import sti_pkg::*;

   localparam int unsigned CB  = COORD_BITS;
   localparam int unsigned DW  = CB + 1;
   localparam int unsigned PW  = 2 * DW;
   localparam int unsigned CW  = 2 * CB + 3;
   localparam int unsigned LB  = CB + 2;
   localparam int unsigned HW  = CW - LB;
   localparam int unsigned LPW = DW + LB + 1;
   localparam int unsigned LSW = LPW + 2;
   localparam int unsigned HPW = DW + HW;
   localparam int unsigned HSW = HPW + 2;
   localparam int unsigned TW  = 3 * CB + 7;

   logic adv;

   logic signed [CB-1:0] pts [POINT_COUNT][3];
   logic [EXT_BITS-1:0]  ext [POINT_COUNT];

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [DW-1:0] u1_ff [DET_COUNT][3], u1_in [DET_COUNT][3];
   logic signed [DW-1:0] p1_ff [DET_COUNT][3], p1_in [DET_COUNT][3];
   logic signed [DW-1:0] q1_ff [DET_COUNT][3], q1_in [DET_COUNT][3];
   logic signed [DW-1:0] u2_ff [DET_COUNT][3];
   logic signed [PW-1:0] ma2_ff [DET_COUNT][3], ma2_in [DET_COUNT][3];
   logic signed [PW-1:0] mb2_ff [DET_COUNT][3], mb2_in [DET_COUNT][3];
   logic signed [DW-1:0] u3_ff [DET_COUNT][3];
   logic signed [CW-1:0] c3_ff [DET_COUNT][3], c3_in [DET_COUNT][3];
   logic signed [LPW-1:0] lo4_ff [DET_COUNT][3], lo4_in [DET_COUNT][3];
   logic signed [HPW-1:0] hi4_ff [DET_COUNT][3], hi4_in [DET_COUNT][3];
   logic signed [LSW-1:0] lo5_ff [DET_COUNT], lo5_in [DET_COUNT];
   logic signed [HSW-1:0] hi5_ff [DET_COUNT], hi5_in [DET_COUNT];
   logic signed [TW-1:0]  tot6 [DET_COUNT];
   logic [DET_COUNT-1:0]  neg6_ff, neg6_in, pos6_ff, pos6_in;
   logic                  rsp_valid_ff;
   logic                  hit_ff, hit_in;
   logic [PAIR_COUNT-1:0] fail;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit   = hit_ff;

   assign ext[PT_ORIGIN] = EXT_BITS'(req_chan.seg_origin);
   assign ext[PT_DEST]   = EXT_BITS'(req_chan.seg_dest);
   assign ext[PT_VA]     = EXT_BITS'(req_chan.tri_vertex_a);
   assign ext[PT_VB]     = EXT_BITS'(req_chan.tri_vertex_b);
   assign ext[PT_VC]     = EXT_BITS'(req_chan.tri_vertex_c);

   // unpack; bits beyond the field read as zero
   always_comb begin
      for (int n = 0; n < POINT_COUNT; n++) begin
         for (int i = 0; i < 3; i++) begin
            pts[n][i] = signed'(ext[n][i*CB +: CB]);
         end
      end
   end

   // stage 1: edge vectors relative to d
   always_comb begin
      for (int d = 0; d < DET_COUNT; d++) begin
         for (int i = 0; i < 3; i++) begin
            u1_in[d][i] = DW'(pts[DET_PTS[d][0]][i]) - DW'(pts[DET_PTS[d][3]][i]);
            p1_in[d][i] = DW'(pts[DET_PTS[d][1]][i]) - DW'(pts[DET_PTS[d][3]][i]);
            q1_in[d][i] = DW'(pts[DET_PTS[d][2]][i]) - DW'(pts[DET_PTS[d][3]][i]);
         end
      end
   end

   // stage 2: cross-product terms; stage 3: cross product
   always_comb begin
      for (int d = 0; d < DET_COUNT; d++) begin
         for (int i = 0; i < 3; i++) begin
            ma2_in[d][i] = p1_ff[d][AXIS_NEXT[i]] * q1_ff[d][AXIS_PREV[i]];
            mb2_in[d][i] = p1_ff[d][AXIS_PREV[i]] * q1_ff[d][AXIS_NEXT[i]];
            c3_in[d][i]  = CW'(ma2_ff[d][i]) - CW'(mb2_ff[d][i]);
         end
      end
   end

   // stage 4: dot product split into low (unsigned) and high limbs
   always_comb begin
      for (int d = 0; d < DET_COUNT; d++) begin
         for (int i = 0; i < 3; i++) begin
            lo4_in[d][i] = u3_ff[d][i] * signed'({1'b0, c3_ff[d][i][LB-1:0]});
            hi4_in[d][i] = u3_ff[d][i] * signed'(c3_ff[d][i][CW-1:LB]);
         end
      end
   end

   // stage 5: limb sums; stage 6: recombine and take sign
   always_comb begin
      for (int d = 0; d < DET_COUNT; d++) begin
         lo5_in[d] = LSW'(lo4_ff[d][0]) + LSW'(lo4_ff[d][1]) + LSW'(lo4_ff[d][2]);
         hi5_in[d] = HSW'(hi4_ff[d][0]) + HSW'(hi4_ff[d][1]) + HSW'(hi4_ff[d][2]);
         tot6[d]   = (TW'(hi5_ff[d]) <<< LB) + TW'(lo5_ff[d]);
         neg6_in[d] = tot6[d][TW-1];
         pos6_in[d] = !tot6[d][TW-1] && (|tot6[d]);
      end
   end

   // stage 7: a pair fails when both volumes share a strict sign
   always_comb begin
      for (int k = 0; k < PAIR_COUNT; k++) begin
         fail[k] = (neg6_ff[2*k] && neg6_ff[2*k+1]) || (pos6_ff[2*k] && pos6_ff[2*k+1]);
      end
      hit_in = !(|fail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_chan.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff   <= u1_in;
         p1_ff   <= p1_in;
         q1_ff   <= q1_in;
         u2_ff   <= u1_ff;
         ma2_ff  <= ma2_in;
         mb2_ff  <= mb2_in;
         u3_ff   <= u2_ff;
         c3_ff   <= c3_in;
         lo4_ff  <= lo4_in;
         hi4_ff  <= hi4_in;
         lo5_ff  <= lo5_in;
         hi5_ff  <= hi5_in;
         neg6_ff <= neg6_in;
         pos6_ff <= pos6_in;
         hit_ff  <= hit_in;
      end
   end

endmodule

@@ sim/testbench.sv @@
// Testbench for segment_triangle_intersect_unit: directed and random segment/triangle words,
// each hit flag checked against a signed-volume predictor computed in wide integers.
// Depends on sti_pkg, sti_req_if, sti_rsp_if and the unit itself.
module testbench;
   import sti_pkg::*;

   localparam int unsigned COORD_BITS = 16;
   localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int SHOW_LIMIT = 10;

   typedef logic signed [127:0] wide_type;
   typedef logic [FIELD_BITS-1:0] word_type;
   typedef struct {
      wide_type x;
      wide_type y;
      wide_type z;
   } point_type;

   logic clock;
   logic reset;

   sti_req_if req_bus ();
   sti_rsp_if rsp_bus ();

   segment_triangle_intersect_unit #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   bit expected_hits[$];
   int words_sent;
   int words_checked;
   int hits_seen;
   int mismatches;
   int idle_cycles;
   bit steady_flow;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic wide_type coord_of(word_type pt_word, int k);
      logic [63:0] ext;
      logic [63:0] u;
      ext = {{(64 - FIELD_BITS){1'b0}}, pt_word};
      u = (ext >> (k * COORD_BITS)) & COORD_MASK;
      if (u[COORD_BITS-1])
         return wide_type'(u) - (wide_type'(1) <<< COORD_BITS);
      return wide_type'(u);
   endfunction

   function automatic point_type unpack_point(word_type pt_word);
      point_type p;
      p.x = coord_of(pt_word, 0);
      p.y = coord_of(pt_word, 1);
      p.z = coord_of(pt_word, 2);
      return p;
   endfunction

   // sign of (a-d).((b-d)x(c-d))
   function automatic int volume_sign(point_type a, point_type b, point_type c, point_type d);
      wide_type ux, uy, uz, px, py, pz, qx, qy, qz, vol;
      ux = a.x - d.x; uy = a.y - d.y; uz = a.z - d.z;
      px = b.x - d.x; py = b.y - d.y; pz = b.z - d.z;
      qx = c.x - d.x; qy = c.y - d.y; qz = c.z - d.z;
      vol = ux * (py * qz - pz * qy) + uy * (pz * qx - px * qz) + uz * (px * qy - py * qx);
      if (vol > 0)
         return 1;
      if (vol < 0)
         return -1;
      return 0;
   endfunction

   function automatic bit same_strict_side(int s1, int s2);
      return (s1 != 0) && (s1 == s2);
   endfunction

   function automatic bit segment_hits_triangle(word_type wo, word_type wd, word_type wa,
                                                word_type wb, word_type wc);
      point_type o, d, a, b, c;
      o = unpack_point(wo);
      d = unpack_point(wd);
      a = unpack_point(wa);
      b = unpack_point(wb);
      c = unpack_point(wc);
      if (same_strict_side(volume_sign(a, b, c, o), volume_sign(a, b, c, d)))
         return 1'b0;
      if (same_strict_side(volume_sign(o, d, a, b), volume_sign(o, d, a, c)))
         return 1'b0;
      if (same_strict_side(volume_sign(o, d, b, a), volume_sign(o, d, b, c)))
         return 1'b0;
      if (same_strict_side(volume_sign(o, d, c, a), volume_sign(o, d, c, b)))
         return 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- helpers
   function automatic word_type pack_point(int x, int y, int z);
      logic [63:0] w;
      w = (64'(x) & COORD_MASK) | ((64'(y) & COORD_MASK) << COORD_BITS)
          | ((64'(z) & COORD_MASK) << (2 * COORD_BITS));
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic word_type random_field();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic int spread(int centre, int r);
      return centre + int'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic word_type point_near(int cx, int cy, int cz, int r);
      return pack_point(spread(cx, r), spread(cy, r), spread(cz, r));
   endfunction

   function automatic int draw_gap();
      if (steady_flow)
         return 0;
      return int'($urandom_range(0, 5));
   endfunction

   task automatic send_pair(input word_type wo, input word_type wd, input word_type wa,
                            input word_type wb, input word_type wc);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.seg_origin   <= wo;
      req_bus.seg_dest     <= wd;
      req_bus.tri_vertex_a <= wa;
      req_bus.tri_vertex_b <= wb;
      req_bus.tri_vertex_c <= wc;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      expected_hits.insert(expected_hits.size(), segment_hits_triangle(wo, wd, wa, wb, wc));
      words_sent++;
   endtask

   // ---------------------------------------------------------------- response side
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (rsp_bus.hit === 1'b1)
            hits_seen++;
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected response word: hit=%b", rsp_bus.hit);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_bus.hit !== want) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("hit mismatch on response %0d: expected %b, got %b",
                           words_checked, want, rsp_bus.hit);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      word_type ta, tb, tc;
      ta = pack_point(-100, -100, 0);
      tb = pack_point(100, -100, 0);
      tc = pack_point(0, 100, 0);
      send_pair('0, '0, '0, '0, '0);
      send_pair(pack_point(0, 0, -100), pack_point(0, 0, 100), ta, tb, tc);
      send_pair(pack_point(0, 0, -100), pack_point(0, 0, 100), ta, tc, tb);
      send_pair(pack_point(0, 0, 50), pack_point(0, 0, 100), ta, tb, tc);
      send_pair(pack_point(0, 0, -100), pack_point(0, 0, -1), ta, tb, tc);
      send_pair(pack_point(500, 0, -100), pack_point(500, 0, 100), ta, tb, tc);
      send_pair(pack_point(0, -300, -100), pack_point(0, -300, 100), ta, tb, tc);
      send_pair(pack_point(-300, 300, -100), pack_point(-300, 300, 100), ta, tb, tc);
      // touching a vertex, an edge, the plane
      send_pair(pack_point(-100, -100, -10), pack_point(-100, -100, 10), ta, tb, tc);
      send_pair(pack_point(0, -100, -10), pack_point(0, -100, 10), ta, tb, tc);
      send_pair(pack_point(0, 0, 0), pack_point(0, 0, 100), ta, tb, tc);
      // coplanar, zero-length, collinear vertices
      send_pair(pack_point(-200, 0, 0), pack_point(200, 0, 0), ta, tb, tc);
      send_pair(pack_point(0, 0, 0), pack_point(0, 0, 0), ta, tb, tc);
      send_pair(pack_point(0, 0, 5), pack_point(0, 0, 5), ta, tb, tc);
      send_pair(pack_point(0, 0, -100), pack_point(0, 0, 100), pack_point(0, 0, 0),
                pack_point(1, 1, 1), pack_point(2, 2, 2));
      // coordinate extremes
      send_pair(pack_point(0, 0, -32768), pack_point(0, 0, 32767),
                pack_point(-32768, -32768, 0), pack_point(32767, -32768, 0),
                pack_point(0, 32767, 0));
      send_pair(pack_point(-32768, -32768, -32768), pack_point(32767, 32767, 32767),
                pack_point(32767, -32768, -32768), pack_point(-32768, 32767, -32768),
                pack_point(-32768, -32768, 32767));
      send_pair(pack_point(32767, 32767, 32767), pack_point(-32768, -32768, -32768),
                pack_point(-32768, 32767, 32767), pack_point(32767, -32768, 32767),
                pack_point(32767, 32767, -32768));
      send_pair('1, '1, '1, '1, '1);
      send_pair('1, '0, '1, '0, '1);
      send_pair('0, '1, '0, '1, '0);
      send_pair(pack_point(-32768, 0, 32767), pack_point(32767, 0, -32768),
                pack_point(0, -32768, -32768), pack_point(0, 32767, 0),
                pack_point(0, -32768, 32767));
   endtask

   task automatic test_random_fields(int count);
      repeat (count)
         send_pair(random_field(), random_field(), random_field(), random_field(),
                   random_field());
   endtask

   task automatic crossing_item();
      int r, lim, cx, cy, cz, px, py, pz, vx, vy, vz;
      int ax, ay, az, bx, by, bz, qx, qy, qz;
      case ($urandom_range(0, 3))
         0: r = 8;
         1: r = 300;
         2: r = 3000;
         default: r = 8000;
      endcase
      lim = 32767 - 3 * r;
      cx = spread(0, lim);
      cy = spread(0, lim);
      cz = spread(0, lim);
      ax = spread(cx, r); ay = spread(cy, r); az = spread(cz, r);
      bx = spread(cx, r); by = spread(cy, r); bz = spread(cz, r);
      qx = spread(cx, r); qy = spread(cy, r); qz = spread(cz, r);
      px = (ax + bx + qx) / 3 + spread(0, r / 4);
      py = (ay + by + qy) / 3 + spread(0, r / 4);
      pz = (az + bz + qz) / 3 + spread(0, r / 4);
      vx = spread(0, r); vy = spread(0, r); vz = spread(0, r);
      send_pair(pack_point(px + vx, py + vy, pz + vz), pack_point(px - vx, py - vy, pz - vz),
                pack_point(ax, ay, az), pack_point(bx, by, bz), pack_point(qx, qy, qz));
   endtask

   task automatic test_crossing_segments(int count);
      repeat (count) crossing_item();
   endtask

   task automatic test_degenerate_geometry(int count);
      word_type wo, wd, wa, wb, wc;
      repeat (count) begin
         wo = point_near(0, 0, 0, 2);
         wd = point_near(0, 0, 0, 2);
         wa = point_near(0, 0, 0, 2);
         wb = point_near(0, 0, 0, 2);
         wc = point_near(0, 0, 0, 2);
         case ($urandom_range(0, 5))
            0: wd = wo;
            1: wo = wa;
            2: wd = wc;
            3: wc = wb;
            4: begin
               wa = pack_point(0, 0, 0);
               wb = pack_point(1, 1, 0);
               wc = pack_point(2, 2, 0);
            end
            default: ;
         endcase
         send_pair(wo, wd, wa, wb, wc);
      end
   endtask

   task automatic test_full_rate(int count);
      steady_flow = 1'b1;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            send_pair(random_field(), random_field(), random_field(), random_field(),
                      random_field());
         else
            crossing_item();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      steady_flow = 1'b0;
      reset <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.seg_origin   <= '0;
      req_bus.seg_dest     <= '0;
      req_bus.tri_vertex_a <= '0;
      req_bus.tri_vertex_b <= '0;
      req_bus.tri_vertex_c <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_fields(250);
      test_crossing_segments(500);
      test_degenerate_geometry(200);
      test_full_rate(250);

      req_bus.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_hits.size() != 0)
         mismatches++;

      $display("%0d segment/triangle words sent, %0d responses checked (%0d hits, %0d misses)",
               words_sent, words_checked, hits_seen, words_checked - hits_seen);
      $display("covered: extremes, touching, coplanar and degenerate cases; random stalls");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/sti_pkg.sv
src/sti_req_if.sv
src/sti_rsp_if.sv
src/segment_triangle_intersect_unit.sv
sim/testbench.sv
